/* rtl/ecgqrs_pkg.sv */
// Shared types, constants and an arithmetic helper for the QRS preprocessing chain.
package ecgqrs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WIDE_W     = 19;
  localparam int LP_DEPTH   = 12;
  localparam int HP_DEPTH   = 32;
  localparam int DV_DEPTH   = 4;
  localparam int WINDOW_LEN = 30;

  localparam int SUM_W        = SAMPLE_W + 1 + $clog2(WINDOW_LEN);
  localparam int MAG_W        = SUM_W - 1;
  localparam int QUOT_W       = SAMPLE_W + 1;
  localparam int RECIP_SHIFT  = 28;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int RECIP_MULT   = (2 ** RECIP_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN;

  localparam logic [2:0] LP_SHIFT = 3'd5;
  localparam logic [2:0] HP_SHIFT = 3'd5;
  localparam logic [2:0] DV_SHIFT = 3'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [RECIP_W-1:0]         recip_t;
  typedef logic [MAG_W+RECIP_W-1:0]   prod_t;
  typedef logic [QUOT_W-1:0]          quot_t;

  // Signed division by a power of two that rounds toward zero.
  function automatic wide_t sdiv_pow2(input wide_t v, input logic [2:0] sh);
    wide_t bias;
    bias = v[WIDE_W-1] ? ((wide_t'(1) <<< sh) - wide_t'(1)) : '0;
    return (v + bias) >>> sh;
  endfunction

endpackage

/* rtl/ecgqrs_cell.sv */
// One delay cell: a 16-bit register that hands its value to the next cell on each shift.
module ecgqrs_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  ecgqrs_pkg::sample_t d_in,
  output ecgqrs_pkg::sample_t d_out
);
  import ecgqrs_pkg::*;

  sample_t val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift_en) begin
      val_r <= d_in;
    end
  end

  assign d_out = val_r;

endmodule

/* rtl/ecg_qrs_preprocess_chain_core.sv */
// Top level of the QRS preprocessing chain: filters, derivative, square and window mean.
// The block takes one sample per clock while in_ready is high and returns one item per
// sample carrying every stage output. It is a six-stage pipeline (low-pass, high-pass,
// derivative, square, window sum, window mean); an accepted item moves through the
// stage registers in that order and out_valid rises when the last stage holds it. The
// delay lines are rows of shift cells that advance only when their stage takes an item,
// so back-pressure stalls the pipe without losing state, and empty stages keep
// accepting while a finished item waits on the output.
module ecg_qrs_preprocess_chain_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ecgqrs_pkg::sample_t in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output ecgqrs_pkg::sample_t out_low_passed,
  output ecgqrs_pkg::sample_t out_high_passed,
  output ecgqrs_pkg::sample_t out_slope,
  output ecgqrs_pkg::sample_t out_squared,
  output ecgqrs_pkg::sample_t out_integrated
);
  import ecgqrs_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic en1, en2, en3, en4, en5, en6;

  sample_t lp_r, lp_old_r, lp2_r, lp3_r, lp4_r, lp5_r;
  sample_t hp_r, hp3_r, hp4_r, hp5_r;
  sample_t d_r, d4_r, d5_r;
  sample_t s_r, s5_r;
  sum_t    sum_r;

  sample_t lpx_chain [LP_DEPTH+1];
  sample_t hpx_chain [HP_DEPTH+1];
  sample_t dv_chain  [DV_DEPTH+1];
  sample_t win_chain [WINDOW_LEN+1];

  wide_t   lp_fir, lp_sum, hp_sum, dv_sum, dv_q;
  sample_t lp_nxt, hp_nxt, d_nxt, s_nxt, mean_nxt;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  sum_t    sum_nxt;
  mag_t    mag;
  prod_t   prod;
  quot_t   quot, quot_signed;

  // Stall propagation through the pipe.
  assign rdy6 = !v6_r || out_ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign en1 = in_valid && rdy1;
  assign en2 = v1_r && rdy2;
  assign en3 = v2_r && rdy3;
  assign en4 = v3_r && rdy4;
  assign en5 = v4_r && rdy5;
  assign en6 = v5_r && rdy6;

  assign in_ready  = rdy1;
  assign out_valid = v6_r;

  assign lpx_chain[0] = in_sample;
  assign hpx_chain[0] = lp_r;
  assign dv_chain[0]  = hp_r;
  assign win_chain[0] = s_r;

  genvar g;
  generate
    for (g = 0; g < LP_DEPTH; g++) begin : g_lpx
      ecgqrs_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(en1),
        .d_in(lpx_chain[g]), .d_out(lpx_chain[g+1])
      );
    end
    for (g = 0; g < HP_DEPTH; g++) begin : g_hpx
      ecgqrs_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(en2),
        .d_in(hpx_chain[g]), .d_out(hpx_chain[g+1])
      );
    end
    for (g = 0; g < DV_DEPTH; g++) begin : g_dv
      ecgqrs_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(en3),
        .d_in(dv_chain[g]), .d_out(dv_chain[g+1])
      );
    end
    for (g = 0; g < WINDOW_LEN; g++) begin : g_win
      ecgqrs_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(en5),
        .d_in(win_chain[g]), .d_out(win_chain[g+1])
      );
    end
  endgenerate

  always_comb begin
    lp_fir = wide_t'(in_sample) - (wide_t'(lpx_chain[6]) <<< 1) + wide_t'(lpx_chain[12]);
    lp_sum = (wide_t'(lp_r) <<< 1) - wide_t'(lp_old_r) + sdiv_pow2(lp_fir, LP_SHIFT);
    lp_nxt = lp_sum[SAMPLE_W-1:0];

    hp_sum = wide_t'(hp_r) - sdiv_pow2(wide_t'(lp_r), HP_SHIFT)
             + wide_t'(hpx_chain[16]) - wide_t'(hpx_chain[17])
             + sdiv_pow2(wide_t'(hpx_chain[32]), HP_SHIFT);
    hp_nxt = hp_sum[SAMPLE_W-1:0];

    dv_sum = (wide_t'(hp_r) <<< 1) + wide_t'(dv_chain[1]) - wide_t'(dv_chain[3])
             - (wide_t'(dv_chain[4]) <<< 1);
    dv_q   = sdiv_pow2(dv_sum, DV_SHIFT);
    d_nxt  = dv_q[SAMPLE_W-1:0];

    sq_full = d_r * d_r;
    s_nxt   = sq_full[SAMPLE_W-1:0];

    sum_nxt = sum_r - sum_t'(win_chain[WINDOW_LEN]) + sum_t'(s_r);

    mag  = sum_r[SUM_W-1] ? mag_t'(-sum_r) : mag_t'(sum_r);
    prod = prod_t'(mag) * prod_t'(recip_t'(RECIP_MULT));
    quot = prod[RECIP_SHIFT +: QUOT_W];
    quot_signed = sum_r[SUM_W-1] ? (quot_t'(0) - quot) : quot;
    mean_nxt = quot_signed[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      v5_r     <= 1'b0;
      v6_r     <= 1'b0;
      lp_r     <= '0;
      lp_old_r <= '0;
      hp_r     <= '0;
      sum_r    <= '0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (en1) begin
        lp_old_r <= lp_r;
        lp_r     <= lp_nxt;
      end
      if (en2) begin
        hp_r <= hp_nxt;
      end
      if (en5) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      lp2_r <= lp_r;
    end
    if (en3) begin
      lp3_r <= lp2_r;
      hp3_r <= hp_r;
      d_r   <= d_nxt;
    end
    if (en4) begin
      lp4_r <= lp3_r;
      hp4_r <= hp3_r;
      d4_r  <= d_r;
      s_r   <= s_nxt;
    end
    if (en5) begin
      lp5_r <= lp4_r;
      hp5_r <= hp4_r;
      d5_r  <= d4_r;
      s5_r  <= s_r;
    end
    if (en6) begin
      out_low_passed  <= lp5_r;
      out_high_passed <= hp5_r;
      out_slope       <= d5_r;
      out_squared     <= s5_r;
      out_integrated  <= mean_nxt;
    end
  end

endmodule

/* test/tb_ecg_qrs_preprocess_chain_core.sv */
// Self-checking testbench for the QRS preprocessing chain core.
`timescale 1ns / 100ps

module tb_ecg_qrs_preprocess_chain_core;
  import ecgqrs_pkg::*;

  localparam int N_DIRECTED   = 25;
  localparam int N_RANDOM     = 1600;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 120;

  typedef struct packed {
    sample_t low_passed;
    sample_t high_passed;
    sample_t slope;
    sample_t squared;
    sample_t integrated;
  } chain_out_t;

  typedef struct {
    sample_t    smp;
    bit         known;
    chain_out_t want;
  } dir_row_t;

  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_BEATS,
    SHAPE_EXTREMES,
    SHAPE_SQUARE
  } shape_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_low_passed;
  sample_t out_high_passed;
  sample_t out_slope;
  sample_t out_squared;
  sample_t out_integrated;

  chain_out_t chain_q[$];
  int         err_count = 0;
  bit         in_burst = 1'b0;

  // Filter state mirrored for prediction.
  int lp_xd[ecgqrs_pkg::LP_DEPTH];
  int lp_y1 = 0;
  int lp_y2 = 0;
  int hp_xd[ecgqrs_pkg::HP_DEPTH];
  int hp_y1 = 0;
  int dv_xd[ecgqrs_pkg::DV_DEPTH];
  int win_sq[ecgqrs_pkg::WINDOW_LEN];
  int win_total = 0;

  string field_name[5] = '{"low_passed", "high_passed", "slope", "squared", "integrated"};

  // Start-up rows are known by hand; the rest exercise extremes and wrap-around.
  dir_row_t dir_tab [N_DIRECTED] = '{
    '{16'sh0000, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
    '{16'sh0000, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
    '{16'sh7fff, 1'b1, '{16'sd1023, -16'sd31, -16'sd7, 16'sd49, 16'sd1}},
    '{16'sh8000, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'shffff, 1'b0, '0},
    '{16'sh0001, 1'b0, '0},
    '{16'sh5555, 1'b0, '0},
    '{16'shaaaa, 1'b0, '0}
  };

  ecg_qrs_preprocess_chain_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_low_passed  (out_low_passed),
    .out_high_passed (out_high_passed),
    .out_slope       (out_slope),
    .out_squared     (out_squared),
    .out_integrated  (out_integrated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int fold_to_16(int v);
    sample_t t;
    t = v[15:0];
    return t;
  endfunction

  function automatic chain_out_t run_chain(sample_t x_in);
    int x;
    int lp;
    int hp;
    int d;
    int sq;
    chain_out_t r;
    x  = x_in;
    lp = fold_to_16(2 * lp_y1 - lp_y2 + (x - 2 * lp_xd[5] + lp_xd[11]) / 32);
    for (int i = ecgqrs_pkg::LP_DEPTH - 1; i > 0; i--) lp_xd[i] = lp_xd[i-1];
    lp_xd[0] = x;
    lp_y2 = lp_y1;
    lp_y1 = lp;

    hp = fold_to_16(hp_y1 - lp / 32 + hp_xd[15] - hp_xd[16] + hp_xd[31] / 32);
    for (int i = ecgqrs_pkg::HP_DEPTH - 1; i > 0; i--) hp_xd[i] = hp_xd[i-1];
    hp_xd[0] = lp;
    hp_y1 = hp;

    d = fold_to_16((2 * hp + dv_xd[0] - dv_xd[2] - 2 * dv_xd[3]) / 8);
    for (int i = ecgqrs_pkg::DV_DEPTH - 1; i > 0; i--) dv_xd[i] = dv_xd[i-1];
    dv_xd[0] = hp;

    sq = fold_to_16(d * d);

    win_total = win_total - win_sq[ecgqrs_pkg::WINDOW_LEN - 1] + sq;
    for (int i = ecgqrs_pkg::WINDOW_LEN - 1; i > 0; i--) win_sq[i] = win_sq[i-1];
    win_sq[0] = sq;

    r.low_passed  = sample_t'(lp);
    r.high_passed = sample_t'(hp);
    r.slope       = sample_t'(d);
    r.squared     = sample_t'(sq);
    r.integrated  = sample_t'(fold_to_16(win_total / ecgqrs_pkg::WINDOW_LEN));
    return r;
  endfunction

  function automatic sample_t shaped_sample(shape_t shape, int k, int amp, int period);
    int phase;
    int v;
    phase = k % period;
    case (shape)
      SHAPE_BEATS: begin
        if (phase < 4) v = amp - phase * (amp / 4);
        else v = $urandom_range(0, 64) - 32;
      end
      SHAPE_EXTREMES: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          default: v = -1;
        endcase
      end
      SHAPE_SQUARE: begin
        v = ((k / period) % 2) ? amp : -amp;
      end
      default: begin
        v = $urandom_range(0, 65535);
      end
    endcase
    return sample_t'(v);
  endfunction

  // Entered and left at a falling edge; in_valid stays high between back-to-back items.
  task automatic offer_sample(sample_t s, bit known, chain_out_t want);
    int gap;
    chain_out_t predicted;
    if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    predicted = run_chain(s);
    chain_q.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  task automatic check_result();
    chain_out_t got;
    chain_out_t want;
    sample_t exp_f;
    sample_t act_f;
    got = '{out_low_passed, out_high_passed, out_slope, out_squared, out_integrated};
    if (chain_q.size() == 0) begin
      $error("result item arrived with no expectation pending");
      err_count++;
      return;
    end
    want = chain_q.pop_front();
    for (int f = 0; f < 5; f++) begin
      exp_f = want[16 * (4 - f) +: 16];
      act_f = got[16 * (4 - f) +: 16];
      if (act_f !== exp_f) begin
        $error("%s: expected %0d, actual %0d", field_name[f], exp_f, act_f);
        err_count++;
      end
    end
  endtask

  initial begin : result_side
    int gap;
    int n_got;
    bit burst;
    n_got = 0;
    burst = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 6);
      // Long hold-offs so the pipe fills and back-pressure reaches the input.
      if (n_got == 200 || n_got == 900) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result();
      n_got++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("ecg_qrs_preprocess_chain_core verification failed");
        $finish;
      end
    end
  end

  initial begin : sample_side
    int n_sent;
    int seg_len;
    int amp;
    int period;
    shape_t shape;
    n_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < N_DIRECTED; r++) begin
      offer_sample(dir_tab[r].smp, dir_tab[r].known, dir_tab[r].want);
    end
    while (n_sent < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    shape = SHAPE_UNIFORM;
        3, 4, 5, 6: shape = SHAPE_BEATS;
        7:          shape = SHAPE_EXTREMES;
        default:    shape = SHAPE_SQUARE;
      endcase
      seg_len = $urandom_range(20, 120);
      amp     = $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 2000);
      period  = $urandom_range(4, 60);
      for (int k = 0; k < seg_len; k++) begin
        offer_sample(shaped_sample(shape, k, amp, period), 1'b0, '0);
      end
      n_sent += seg_len;
    end
    in_valid <= 1'b0;
    while (chain_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ecg_qrs_preprocess_chain_core verification clean");
    end else begin
      $display("ecg_qrs_preprocess_chain_core verification failed");
    end
    $finish;
  end

endmodule

/* ecg_qrs_preprocess_chain_core.f */
rtl/ecgqrs_pkg.sv
rtl/ecgqrs_cell.sv
rtl/ecg_qrs_preprocess_chain_core.sv
test/tb_ecg_qrs_preprocess_chain_core.sv
